[rtl/drxc_pkg.sv]
package drxc_pkg;

    // command codes of the input channel
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SEQ    = 2'd1,
        OP_SETPOS = 2'd2,
        OP_POS    = 2'd3
    } op_t;

    localparam int QUEUE_DEPTH = 2;

    // classified item handed from front to back
    // arg31/arg30 carry reduced counters for a load, reduced positions for set position
    typedef struct packed {
        op_t         op;
        logic [7:0]  data_byte;
        logic [30:0] word31;
        logic [29:0] word30;
        logic [4:0]  arg31;
        logic [4:0]  arg30;
    } item_t;

    // x mod 31, using 2^5 = 1 mod 31
    function automatic logic [4:0] mod31(input logic [31:0] x);
        logic [7:0] s;
        logic [5:0] t;
        s = 8'(x[4:0]) + 8'(x[9:5]) + 8'(x[14:10]) + 8'(x[19:15])
          + 8'(x[24:20]) + 8'(x[29:25]) + 8'(x[31:30]);
        t = 6'(s[4:0]) + 6'(s[7:5]);
        return (t >= 6'd31) ? 5'(t - 6'd31) : t[4:0];
    endfunction

    // x mod 15, using 2^4 = 1 mod 15
    function automatic logic [3:0] mod15(input logic [31:0] x);
        logic [6:0] s;
        logic [4:0] t;
        s = 7'(x[3:0]) + 7'(x[7:4]) + 7'(x[11:8]) + 7'(x[15:12])
          + 7'(x[19:16]) + 7'(x[23:20]) + 7'(x[27:24]) + 7'(x[31:28]);
        t = 5'(s[3:0]) + 5'(s[6:4]);
        return (t >= 5'd15) ? 4'(t - 5'd15) : t[3:0];
    endfunction

    // x mod 30 from x mod 15 and the parity of x
    function automatic logic [4:0] mod30(input logic [31:0] x);
        logic [3:0] a;
        a = mod15(x);
        return (a[0] == x[0]) ? {1'b0, a} : ({1'b0, a} + 5'd15);
    endfunction

endpackage

[rtl/drxc_front.sv]
module drxc_front (
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [7:0]         data_byte,
    input  logic [31:0]        offset,
    input  logic [30:0]        load_sum31,
    input  logic [29:0]        load_sum30,
    input  logic [7:0]         load_count31,
    input  logic [7:0]         load_count30,
    input  logic               q_full,
    output logic               q_push,
    output drxc_pkg::item_t    q_item
);

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.op        = drxc_pkg::op_t'(cmd);
        q_item.data_byte = data_byte;
        q_item.word31    = load_sum31;
        q_item.word30    = load_sum30;
        case (drxc_pkg::op_t'(cmd))
            drxc_pkg::OP_LOAD:
            begin
                q_item.arg31 = drxc_pkg::mod31({24'd0, load_count31});
                q_item.arg30 = drxc_pkg::mod30({24'd0, load_count30});
            end
            drxc_pkg::OP_SETPOS:
            begin
                q_item.arg31 = drxc_pkg::mod31(offset);
                q_item.arg30 = drxc_pkg::mod30(offset);
            end
            default:
            begin
                q_item.arg31 = '0;
                q_item.arg30 = '0;
            end
        endcase
    end

endmodule

[rtl/drxc_queue.sv]
module drxc_queue #(
    parameter int Depth = drxc_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  drxc_pkg::item_t    push_item,
    output logic               full,
    input  logic               pop,
    output drxc_pkg::item_t    pop_item,
    output logic               empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    drxc_pkg::item_t mem [Depth];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full     = (count_reg == CntW'(Depth));
    assign empty    = (count_reg == '0);
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/drxc_back.sv]
module drxc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cyclic_mode,
    input  logic               q_empty,
    input  drxc_pkg::item_t    q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [30:0]        sum31,
    output logic [29:0]        sum30,
    output logic [4:0]         count31,
    output logic [4:0]         count30
);

    logic [30:0] word31_reg, word31_next;
    logic [29:0] word30_reg, word30_next;
    logic [4:0]  ctr31_reg, ctr31_next;
    logic [4:0]  ctr30_reg, ctr30_next;
    logic [4:0]  pos31_reg, pos31_next;
    logic [4:0]  pos30_reg, pos30_next;
    logic        out_valid_reg, out_valid_next;

    logic [30:0] seq31;
    logic [29:0] seq30;
    logic [4:0]  d31, d30, s31, s30;
    logic [61:0] wide31;
    logic [59:0] wide30;

    // state only moves when the result slot is free, so it doubles as the output register
    assign q_pop     = !q_empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign sum31     = word31_reg;
    assign sum30     = word30_reg;
    assign count31   = ctr31_reg;
    assign count30   = ctr30_reg;

    always_comb
    begin
        // sequential fold: xor then rotate by one or by eight
        seq31 = word31_reg ^ {23'd0, q_item.data_byte};
        seq30 = word30_reg ^ {22'd0, q_item.data_byte};
        if (cyclic_mode)
        begin
            seq31 = {seq31[22:0], seq31[30:23]};
            seq30 = {seq30[21:0], seq30[29:22]};
        end
        else
        begin
            seq31 = {seq31[29:0], seq31[30]};
            seq30 = {seq30[28:0], seq30[29]};
        end

        // positional fold: distance counter minus position, scaled by the rotation step
        d31 = (ctr31_reg >= pos31_reg) ? (ctr31_reg - pos31_reg)
                                       : (ctr31_reg + 5'd31 - pos31_reg);
        d30 = (ctr30_reg >= pos30_reg) ? (ctr30_reg - pos30_reg)
                                       : (ctr30_reg + 5'd30 - pos30_reg);
        // times eight mod 31 is a 5-bit rotate by three
        s31 = cyclic_mode ? {d31[1:0], d31[4:2]} : d31;
        s30 = cyclic_mode ? drxc_pkg::mod30({24'd0, d30, 3'd0}) : d30;
        wide31 = {23'd0, q_item.data_byte, 23'd0, q_item.data_byte} << s31;
        wide30 = {22'd0, q_item.data_byte, 22'd0, q_item.data_byte} << s30;

        word31_next    = word31_reg;
        word30_next    = word30_reg;
        ctr31_next     = ctr31_reg;
        ctr30_next     = ctr30_reg;
        pos31_next     = pos31_reg;
        pos30_next     = pos30_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (q_pop)
        begin
            out_valid_next = 1'b1;
            case (q_item.op)
                drxc_pkg::OP_LOAD:
                begin
                    word31_next = q_item.word31;
                    word30_next = q_item.word30;
                    ctr31_next  = q_item.arg31;
                    ctr30_next  = q_item.arg30;
                end
                drxc_pkg::OP_SEQ:
                begin
                    word31_next = seq31;
                    word30_next = seq30;
                    ctr31_next  = (ctr31_reg == 5'd30) ? 5'd0 : ctr31_reg + 5'd1;
                    ctr30_next  = (ctr30_reg == 5'd29) ? 5'd0 : ctr30_reg + 5'd1;
                end
                drxc_pkg::OP_SETPOS:
                begin
                    pos31_next = q_item.arg31;
                    pos30_next = q_item.arg30;
                end
                drxc_pkg::OP_POS:
                begin
                    word31_next = word31_reg ^ wide31[61:31];
                    word30_next = word30_reg ^ wide30[59:30];
                    pos31_next  = (pos31_reg == 5'd30) ? 5'd0 : pos31_reg + 5'd1;
                    pos30_next  = (pos30_reg == 5'd29) ? 5'd0 : pos30_reg + 5'd1;
                end
                default:
                begin
                    word31_next = word31_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word31_reg    <= '0;
            word30_reg    <= '0;
            ctr31_reg     <= '0;
            ctr30_reg     <= '0;
            pos31_reg     <= '0;
            pos30_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            word31_reg    <= word31_next;
            word30_reg    <= word30_next;
            ctr31_reg     <= ctr31_next;
            ctr30_reg     <= ctr30_next;
            pos31_reg     <= pos31_next;
            pos30_reg     <= pos30_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/dual_rotating_xor_checksum.sv]
// dual rotating xor checksum: a 31-bit and a 30-bit word with byte counters mod 31 / mod 30
// input channel: in_valid/in_ready transfer one command (load, sequential byte,
//   set position, positional byte) with all its payload fields
// output channel: out_valid/out_ready transfer one result per command, holding both
//   words and both counters as they stand after that command
// config channel: cfg_valid/cfg_ready transfer the cyclic_mode bit (rotate by 8 vs 1);
//   cfg_ready is always high, write only while the block is idle
// a result is offered once its command has passed through the queue and the back-end state register
// throughput: one command per cycle while the receiver takes each result, set by the state update in the back end
// the front end reduces offsets and loaded counters mod 31 / 30 and pushes into a
//   two-entry queue, so input transfers keep going while a result waits
// when the receiver stalls, the result and state hold, the queue fills, and in_ready
//   drops once it is full
// reset clears words, counters, positions, mode, queue and the result valid
module dual_rotating_xor_checksum #(
    parameter int QueueDepth = drxc_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  data_byte,
    input  logic [31:0] offset,
    input  logic [30:0] load_sum31,
    input  logic [29:0] load_sum30,
    input  logic [7:0]  load_count31,
    input  logic [7:0]  load_count30,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [30:0] sum31,
    output logic [29:0] sum30,
    output logic [4:0]  count31,
    output logic [4:0]  count30
);

    logic            cyclic_mode_reg;
    logic            q_push, q_pop, q_full, q_empty;
    drxc_pkg::item_t push_item, pop_item;

    // mode register, always ready for a transfer
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyclic_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            cyclic_mode_reg <= cfg_data;
        end
    end

    // front end: accept and classify, reduce wide operands
    drxc_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .data_byte    (data_byte),
        .offset       (offset),
        .load_sum31   (load_sum31),
        .load_sum30   (load_sum30),
        .load_count31 (load_count31),
        .load_count30 (load_count30),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    // decoupling queue between front and back
    drxc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    // back end: checksum state, doubles as the result register
    drxc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cyclic_mode (cyclic_mode_reg),
        .q_empty     (q_empty),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sum31       (sum31),
        .sum30       (sum30),
        .count31     (count31),
        .count30     (count30)
    );

endmodule
